// ===== src/u8l1_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8l1_pkg: shared types and functions of the UTF-8 to Latin-1 converter
// Transfer payloads, the job record passed from front to back, lead-byte
// classification and the code-point build of a complete sequence.
// ---------------------------------------------------------------------------
package u8l1_pkg;

   // Transfer payloads
   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] latin1_byte;
      logic       last_of_string;
   } rsp_type;

   localparam logic [7:0] REPL_RESET = 8'h3F;

   // One job holds every result caused by one input byte
   localparam int unsigned MAX_SLOTS = 4;
   localparam int unsigned SLOT_W    = $clog2(MAX_SLOTS);
   localparam int unsigned CNT_W     = $clog2(MAX_SLOTS + 1);

   typedef struct packed {
      logic [MAX_SLOTS-1:0][7:0] chars;
      logic [CNT_W-1:0]          count;
      logic                      last;
   } job_type;

   // Job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Lead-byte classes
   typedef enum logic [2:0] {
      LEAD_ASCII,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_BAD
   } lead_type;

   function automatic lead_type classify(input logic [7:0] c);
      lead_type lt;
      case (c) inside
         [8'h00:8'h7F]: lt = LEAD_ASCII;
         [8'hC0:8'hDF]: lt = LEAD_TWO;
         [8'hE0:8'hEF]: lt = LEAD_THREE;
         [8'hF0:8'hF7]: lt = LEAD_FOUR;
         default:       lt = LEAD_BAD;
      endcase
      return lt;
   endfunction

   // Further bytes a lead byte collects
   function automatic logic [1:0] follow_count(input lead_type lt);
      logic [1:0] k;
      case (lt)
         LEAD_TWO:   k = 2'd1;
         LEAD_THREE: k = 2'd2;
         LEAD_FOUR:  k = 2'd3;
         default:    k = 2'd0;
      endcase
      return k;
   endfunction

   // Build the code point of lead s[0] plus k further bytes; keep it if it
   // fits in eight bits, else give the replacement byte
   function automatic logic [7:0] map_seq(input logic [3:0][7:0] s,
                                          input logic [1:0]      k,
                                          input logic [7:0]      repl);
      logic       fits;
      logic [7:0] val;
      case (k)
         2'd1: begin
            fits = (s[0][4:2] == 3'd0);
            val  = {s[0][1:0], s[1][5:0]};
         end
         2'd2: begin
            fits = (s[0][3:0] == 4'd0) && (s[1][5:2] == 4'd0);
            val  = {s[1][1:0], s[2][5:0]};
         end
         2'd3: begin
            fits = (s[0][2:0] == 3'd0) && (s[1][5:0] == 6'd0) && (s[2][5:2] == 4'd0);
            val  = {s[2][1:0], s[3][5:0]};
         end
         default: begin
            fits = 1'b1;
            val  = s[0];
         end
      endcase
      return fits ? val : repl;
   endfunction

endpackage
`default_nettype wire

// ===== src/u8l1_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8l1_front: byte intake and sequence decoder
// Holds a pending multi-byte sequence, decodes complete sequences and the
// string tail, and turns each accepted byte into at most one job of results.
// ---------------------------------------------------------------------------
module u8l1_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire u8l1_pkg::req_type req_data,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data,
   output logic                   push,
   output u8l1_pkg::job_type      push_data
);
   import u8l1_pkg::*;

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      held_count_ff, held_count_in;
   logic [1:0]      needed_ff, needed_in;
   logic [7:0]      repl_ff;

   logic [7:0][7:0] tail;
   job_type         tail_job;
   job_type         job;

   // Replacement byte register
   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_RESET;
      end else if (csr_wr_en) begin
         repl_ff <= csr_wr_data;
      end
   end

   // Line up held bytes and the new byte, zero beyond
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         if (j < int'(held_count_ff)) begin
            tail[j] = held_ff[j];
         end else if (j == int'(held_count_ff)) begin
            tail[j] = req_data.byte_in;
         end else begin
            tail[j] = 8'h00;
         end
      end
   end

   // Decode the whole tail at end of string, one result per step
   always_comb begin : tail_decode
      logic [2:0]      pos;
      logic [2:0]      n;
      logic [7:0]      cur;
      lead_type        lt;
      logic [1:0]      k;
      logic [3:0][7:0] win;
      tail_job = '0;
      pos      = '0;
      n        = {1'b0, held_count_ff} + 3'd1;
      for (int st = 0; st < MAX_SLOTS; st++) begin
         cur = tail[pos];
         lt  = classify(cur);
         k   = follow_count(lt);
         for (int m = 0; m < 4; m++) begin
            win[m] = tail[pos + 3'(m)];
         end
         if (pos < n) begin
            if (lt == LEAD_ASCII) begin
               tail_job.chars[st] = cur;
               pos = pos + 3'd1;
            end else if (lt == LEAD_BAD) begin
               tail_job.chars[st] = repl_ff;
               pos = pos + 3'd1;
            end else if ((pos + {1'b0, k}) < n) begin
               tail_job.chars[st] = map_seq(win, k, repl_ff);
               pos = pos + {1'b0, k} + 3'd1;
            end else begin
               tail_job.chars[st] = repl_ff;
               pos = pos + 3'd1;
            end
            tail_job.count = CNT_W'(st + 1);
         end
      end
      tail_job.last = 1'b1;
   end

   // Advance the pending sequence and form this byte's job
   always_comb begin : step
      lead_type lt;
      lt            = classify(req_data.byte_in);
      held_in       = held_ff;
      held_count_in = held_count_ff;
      needed_in     = needed_ff;
      job           = '0;
      if (req_data.end_of_string) begin
         job           = tail_job;
         held_count_in = 2'd0;
         needed_in     = 2'd0;
      end else if (needed_ff == 2'd0) begin
         if (lt == LEAD_ASCII) begin
            job.chars[0] = req_data.byte_in;
            job.count    = CNT_W'(1);
         end else if (lt == LEAD_BAD) begin
            job.chars[0] = repl_ff;
            job.count    = CNT_W'(1);
         end else begin
            held_in[0]    = req_data.byte_in;
            held_count_in = 2'd1;
            needed_in     = follow_count(lt);
         end
      end else if (needed_ff == 2'd1) begin
         job.chars[0]  = map_seq(tail[3:0], held_count_ff, repl_ff);
         job.count     = CNT_W'(1);
         held_count_in = 2'd0;
         needed_in     = 2'd0;
      end else begin
         held_in[held_count_ff] = req_data.byte_in;
         held_count_in          = held_count_ff + 2'd1;
         needed_in              = needed_ff - 2'd1;
      end
   end

   // Sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         needed_ff     <= 2'd0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         needed_ff     <= needed_in;
      end
   end

   // Held bytes carry no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
   end

   assign push      = accept && (job.count != '0);
   assign push_data = job;

endmodule
`default_nettype wire

// ===== src/u8l1_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8l1_queue: job queue between decoder and output serialiser
// A short first-in first-out store of jobs so each side can stall alone.
// ---------------------------------------------------------------------------
module u8l1_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire u8l1_pkg::job_type push_data,
   input  wire logic              pop,
   output u8l1_pkg::job_type      pop_data,
   output u8l1_pkg::qstat_type    status
);
   import u8l1_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Store a job on push
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill level
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule
`default_nettype wire

// ===== src/u8l1_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8l1_back: output serialiser
// Takes queued jobs and sends their results one transfer a cycle, unless
// rsp_stall holds the registered output stage; flags the last of a string.
// ---------------------------------------------------------------------------
module u8l1_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire u8l1_pkg::job_type   pop_data,
   input  wire u8l1_pkg::qstat_type status,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output u8l1_pkg::rsp_type        rsp_data
);
   import u8l1_pkg::*;

   job_type           job_ff;
   logic              job_valid_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic out_free;
   logic emit;
   logic job_done;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = job_valid_ff && out_free;
   assign job_done = emit && (({1'b0, slot_ff} + CNT_W'(1)) == job_ff.count);
   assign pop      = !status.empty && (!job_valid_ff || job_done);

   // Load the next job and walk its slots
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else if (pop) begin
         job_valid_ff <= 1'b1;
         slot_ff      <= '0;
      end else if (job_done) begin
         job_valid_ff <= 1'b0;
      end else if (emit) begin
         slot_ff <= slot_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= pop_data;
      end
   end

   // Output register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff.latin1_byte    <= job_ff.chars[slot_ff];
         rsp_data_ff.last_of_string <= job_ff.last && job_done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== src/utf8_to_latin1_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Results pass through the job queue, the back's job register and the output
// register. Bytes are accepted one per cycle while the queue is not full;
// the output register sends one transfer per cycle while rsp_stall is low.
// A four-job queue parts intake from output; req_stall rises when it is full.
// Reset (synchronous): drops any pending sequence, empties the queue and
// sets the replacement byte to '?'.
// ---------------------------------------------------------------------------
// utf8_to_latin1_stream: streaming UTF-8 to Latin-1 converter
// Decoder front, job queue and output serialiser.
// ---------------------------------------------------------------------------
module utf8_to_latin1_stream (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire u8l1_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output u8l1_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data
);
   import u8l1_pkg::*;

   logic      accept;
   logic      push;
   job_type   push_data;
   logic      pop;
   job_type   pop_data;
   qstat_type q_status;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   u8l1_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_data   (push_data)
   );

   u8l1_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   u8l1_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .status    (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== src/u8l1_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u8l1_checker: port-level checks of the converter
// Output hold under stall and quiet start after reset.
// ---------------------------------------------------------------------------
module u8l1_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire u8l1_pkg::rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_valid_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   a_rsp_data_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // Leave reset empty and ready to take bytes
   a_reset_ready : assert property (@(posedge clock)
      reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

   // No result can reach the output register straight after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> ##1 !rsp_valid)
      else $error("result appeared too soon after reset");

endmodule

bind utf8_to_latin1_stream u8l1_checker u_checker (.*);
`default_nettype wire

// ===== test/utf8_to_latin1_stream_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_latin1_stream_tb: self-checking bench of the UTF-8 to Latin-1 stream
// Sends UTF-8 strings byte by byte, predicts the Latin-1 output of each byte
// with an in-bench decoder and checks every output transfer in order, while
// both sides pause at random and the replacement byte is changed per phase.
// ---------------------------------------------------------------------------
module utf8_to_latin1_stream_tb;
   import u8l1_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned PHASE_BYTES    = 108;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;

   // Pending input bytes and the Latin-1 output still owed by the block
   req_type     byte_queue[$];
   rsp_type     latin1_due[$];

   // Decoder state mirrored in the bench
   logic [7:0]  held[3];
   int unsigned held_n;
   int unsigned need_n;
   logic [7:0]  repl_char;

   int unsigned gap_pct;
   int unsigned stall_pct;
   int unsigned gap_left;
   int unsigned stall_left;
   int unsigned quiet_cycles;
   int unsigned bytes_sent;
   int unsigned chars_checked;
   int unsigned strings_sent;
   int unsigned settings_used;
   int unsigned mismatches;

   utf8_to_latin1_stream DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Classify a byte as the start of a sequence
   function automatic lead_type lead_of(input logic [7:0] c);
      if (c <= 8'h7F) return LEAD_ASCII;
      if (c >= 8'hC0 && c <= 8'hDF) return LEAD_TWO;
      if (c >= 8'hE0 && c <= 8'hEF) return LEAD_THREE;
      if (c >= 8'hF0 && c <= 8'hF7) return LEAD_FOUR;
      return LEAD_BAD;
   endfunction

   function automatic int unsigned follow_bytes(input lead_type lt);
      case (lt)
         LEAD_TWO:   return 1;
         LEAD_THREE: return 2;
         LEAD_FOUR:  return 3;
         default:    return 0;
      endcase
   endfunction

   // Code point of the sequence at s[at] with k further bytes, as Latin-1
   function automatic logic [7:0] seq_to_latin1(input logic [7:0] s[4],
                                                input int unsigned at,
                                                input int unsigned k);
      int unsigned cp;
      int unsigned j;
      case (k)
         1:       cp = s[at] & 8'h1F;
         2:       cp = s[at] & 8'h0F;
         default: cp = s[at] & 8'h07;
      endcase
      for (j = 1; j <= k; j++) cp = (cp << 6) | (s[at + j] & 8'h3F);
      return (cp <= 32'hFF) ? cp[7:0] : repl_char;
   endfunction

   // Work out the output of one accepted byte and queue it
   function automatic void predict_latin1(input req_type it);
      logic [7:0]  seq[4];
      logic [7:0]  outs[4];
      int unsigned n;
      int unsigned i;
      int unsigned k;
      int unsigned cnt;
      lead_type    lt;
      rsp_type     r;
      n   = 0;
      cnt = 0;
      for (i = 0; i < 4; i++) seq[i] = 8'h00;
      for (i = 0; i < held_n; i++) begin
         seq[n] = held[i];
         n++;
      end
      if (it.end_of_string) begin
         // decode the whole tail again from its start
         seq[n] = it.byte_in;
         n++;
         i = 0;
         while (i < n) begin
            lt = lead_of(seq[i]);
            k  = follow_bytes(lt);
            if (lt == LEAD_ASCII) begin
               outs[cnt] = seq[i];
               i++;
            end else if (lt == LEAD_BAD || i + k >= n) begin
               outs[cnt] = repl_char;
               i++;
            end else begin
               outs[cnt] = seq_to_latin1(seq, i, k);
               i += k + 1;
            end
            cnt++;
         end
         held_n = 0;
         need_n = 0;
      end else if (need_n == 0) begin
         lt = lead_of(it.byte_in);
         if (lt == LEAD_ASCII || lt == LEAD_BAD) begin
            outs[0] = (lt == LEAD_ASCII) ? it.byte_in : repl_char;
            cnt     = 1;
         end else begin
            held[0] = it.byte_in;
            held_n  = 1;
            need_n  = follow_bytes(lt);
         end
      end else if (need_n == 1) begin
         // last further byte: top bits are not checked
         seq[n]  = it.byte_in;
         outs[0] = seq_to_latin1(seq, 0, n);
         cnt     = 1;
         held_n  = 0;
         need_n  = 0;
      end else begin
         if (held_n < 3) begin
            held[held_n] = it.byte_in;
            held_n++;
         end
         need_n--;
      end
      for (i = 0; i < cnt; i++) begin
         r.latin1_byte    = outs[i];
         r.last_of_string = it.end_of_string && (i == cnt - 1);
         latin1_due.insert(latin1_due.size(), r);
      end
   endfunction

   // Driver: hold a stalled byte, otherwise advance or pause
   always @(posedge clock) begin : drive_req
      logic taken;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (taken) begin
            predict_latin1(req_data);
            bytes_sent++;
         end
         if (!(req_valid && !taken)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0 && $urandom_range(99) < gap_pct) begin
               gap_left = $urandom_range(13, 1) - 1;
               req_valid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req_data  <= byte_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each output transfer, then pick the next stall
   always @(posedge clock) begin : watch_rsp
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (latin1_due.size() == 0) begin
               $display("%0t: unexpected transfer: expected none, got byte %h last %b",
                        $time, rsp_data.latin1_byte, rsp_data.last_of_string);
               mismatches++;
            end else begin
               want = latin1_due.pop_front();
               chars_checked++;
               if (rsp_data.latin1_byte !== want.latin1_byte) begin
                  $display("%0t: latin1_byte mismatch: expected %h, got %h",
                           $time, want.latin1_byte, rsp_data.latin1_byte);
                  mismatches++;
               end
               if (rsp_data.last_of_string !== want.last_of_string) begin
                  $display("%0t: last_of_string mismatch: expected %b, got %b",
                           $time, want.last_of_string, rsp_data.last_of_string);
                  mismatches++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(99) < stall_pct) begin
            stall_left = $urandom_range(13, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if no transfer moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_byte(input logic [7:0] b, input logic eos);
      req_type it;
      it.byte_in       = b;
      it.end_of_string = eos;
      byte_queue.insert(byte_queue.size(), it);
   endtask

   // Queue a whole string; the last byte carries the end flag
   task automatic add_string(input logic [7:0] s[$]);
      int unsigned i;
      for (i = 0; i < s.size(); i++) add_byte(s[i], i == s.size() - 1);
      strings_sent++;
   endtask

   // Random string of mostly well-formed characters, sometimes cut short
   task automatic add_random_string();
      logic [7:0]  s[$];
      int unsigned chars;
      int unsigned c;
      int unsigned j;
      int unsigned cp;
      int unsigned keep;
      chars = $urandom_range(10, 1);
      for (c = 0; c < chars; c++) begin
         case ($urandom_range(9))
            0, 1, 2: s.insert(s.size(), 8'($urandom_range(8'h7F)));
            3, 4: begin
               cp = $urandom_range(255);
               s.insert(s.size(), 8'hC0 | cp[7:6]);
               s.insert(s.size(), 8'h80 | cp[5:0]);
            end
            5: begin
               s.insert(s.size(), 8'($urandom_range(8'hDF, 8'hC0)));
               s.insert(s.size(), 8'($urandom_range(255)));
            end
            6: begin
               s.insert(s.size(), $urandom_range(1) ? 8'hE0
                                                    : 8'($urandom_range(8'hEF, 8'hE0)));
               s.insert(s.size(), $urandom_range(1) ? 8'h80 | 8'($urandom_range(3))
                                                    : 8'($urandom_range(255)));
               s.insert(s.size(), 8'($urandom_range(255)));
            end
            7: begin
               s.insert(s.size(), $urandom_range(1) ? 8'hF0
                                                    : 8'($urandom_range(8'hF7, 8'hF0)));
               s.insert(s.size(), $urandom_range(1) ? 8'h80 : 8'($urandom_range(255)));
               s.insert(s.size(), $urandom_range(1) ? 8'h80 | 8'($urandom_range(3))
                                                    : 8'($urandom_range(255)));
               s.insert(s.size(), 8'($urandom_range(255)));
            end
            8: s.insert(s.size(), $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                    : 8'($urandom_range(8'hFF, 8'hF8)));
            default: s.insert(s.size(), 8'($urandom_range(255)));
         endcase
      end
      // cut the string inside a sequence now and then
      if ($urandom_range(4) == 0) begin
         keep = $urandom_range(s.size(), 1);
         for (j = s.size(); j > keep; j--) void'(s.pop_back());
      end
      add_string(s);
   endtask

   // Let every queued byte and owed output pass, then let the block settle
   task automatic drain();
      while (byte_queue.size() > 0 || req_valid || latin1_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_repl(input logic [7:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      repl_char = v;
      settings_used++;
   endtask

   initial begin : run
      logic [7:0]  repl_plan[4];
      int unsigned gap_plan[4];
      int unsigned stall_plan[4];
      int unsigned p;
      int unsigned mark;
      held_n        = 0;
      need_n        = 0;
      repl_char     = REPL_RESET;
      gap_pct       = 20;
      stall_pct     = 20;
      bytes_sent    = 0;
      chars_checked = 0;
      strings_sent  = 0;
      settings_used = 1;
      mismatches    = 0;
      repl_plan  = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};
      gap_plan   = '{30, 10, 40, 0};
      stall_plan = '{30, 40, 5, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every lead class, overlong and unrepresentable
      // forms, unchecked further bytes, and strings ending mid-sequence
      add_string('{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hC3, 8'hA9, 8'hC0, 8'h80,
                   8'hC2, 8'hFF, 8'hE0, 8'h83, 8'hBF, 8'hF0, 8'h80, 8'h83,
                   8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h41});
      add_string('{8'hC3});
      add_string('{8'hE0, 8'h83});
      add_string('{8'hF0, 8'h41, 8'h42});
      drain();

      // Random phases, each under its own replacement byte and pacing
      for (p = 0; p < 4; p++) begin
         write_repl(repl_plan[p]);
         gap_pct   = gap_plan[p];
         stall_pct = stall_plan[p];
         mark      = byte_queue.size();
         while (byte_queue.size() - mark < PHASE_BYTES) add_random_string();
         drain();
      end

      $display("Sent %0d bytes in %0d strings under %0d replacement settings;",
               bytes_sent, strings_sent, settings_used);
      $display("checked %0d Latin-1 transfers, %0d mismatches.", chars_checked, mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/u8l1_pkg.sv
src/u8l1_front.sv
src/u8l1_queue.sv
src/u8l1_back.sv
src/utf8_to_latin1_stream.sv
src/u8l1_checker.sv
test/utf8_to_latin1_stream_tb.sv
